FILE: rtl/bpc_pkg.sv
package bpc_pkg;

  // Default number of fractional bits on both results
  localparam int OUT_FRAC_BITS_DEF = 8;

  // Field widths
  localparam int CountW  = 10;
  localparam int CoefW   = 16;
  localparam int C12W    = 14;
  localparam int CfgAddrW = 2;
  localparam int KpaW    = 15;
  localparam int DegcW   = 16;
  localparam int InDataW  = 24;
  localparam int OutDataW = 32;

  // Compensated pressure, signed, in units of 2^-22
  localparam int PcompW     = 38;
  localparam int PcompFrac  = 22;
  localparam int PcompClipW = 32;
  localparam logic [PcompClipW-1:0] PcompMax = 32'd1023 << PcompFrac;

  // Constant divisors of the two conversions
  localparam int KpaDivisor  = 1023;
  localparam int DegcDivisor = 535;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_A0  = 2'd0,
    CFG_B1  = 2'd1,
    CFG_B2  = 2'd2,
    CFG_C12 = 2'd3
  } bpc_cfg_e;

  // Coefficient set handed to the datapath
  typedef struct packed {
    logic signed [CoefW-1:0] a0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic        [C12W-1:0]  c12;
  } bpc_coef_t;

endpackage

FILE: rtl/bpc_coef.sv
module bpc_coef (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bpc_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [bpc_pkg::CoefW-1:0]          cfg_wdata_i,
  output bpc_pkg::bpc_coef_t                 coef_o
);

  bpc_pkg::bpc_coef_t coef_q;
  bpc_pkg::bpc_coef_t coef_d;

  // Register write decode
  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      case (bpc_pkg::bpc_cfg_e'(cfg_addr_i))
        bpc_pkg::CFG_A0:  coef_d.a0  = cfg_wdata_i;
        bpc_pkg::CFG_B1:  coef_d.b1  = cfg_wdata_i;
        bpc_pkg::CFG_B2:  coef_d.b2  = cfg_wdata_i;
        bpc_pkg::CFG_C12: coef_d.c12 = cfg_wdata_i[bpc_pkg::C12W-1:0];
        default:          coef_d     = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

FILE: rtl/bpc_poly.sv
// Three-stage evaluation of a0 + (b1 + c12*T)*P + b2*T in units of 2^-22,
// with the temperature numerator prepared alongside.
module bpc_poly #(
  parameter int OUT_FRAC_BITS = bpc_pkg::OUT_FRAC_BITS_DEF,
  localparam int MagW = 16 + OUT_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [bpc_pkg::CountW-1:0]          pressure_count_i,
  input  logic [bpc_pkg::CountW-1:0]          temperature_count_i,
  input  bpc_pkg::bpc_coef_t                  coef_i,
  output logic                                valid_o,
  output logic signed [bpc_pkg::PcompW-1:0]   pcomp_o,
  output logic [MagW-1:0]                     tmag_o,
  output logic                                tneg_o
);

  // Stage 1 signals
  logic                 v1_q;
  logic [9:0]           p1_q;
  logic [23:0]          ct1_q, ct1_d;
  logic signed [25:0]   bt1_q, bt1_d;
  logic [MagW-1:0]      tmag1_q, tmag1_d;
  logic                 tneg1_q, tneg1_d;
  logic [16:0]          tmul;
  logic signed [17:0]   tnum;
  logic [17:0]          tabs;

  // Stage 2 signals
  logic                 v2_q;
  logic signed [25:0]   inner;
  logic signed [35:0]   vp2_q, vp2_d;
  logic signed [35:0]   w2_q, w2_d;
  logic [MagW-1:0]      tmag2_q;
  logic                 tneg2_q;

  // Stage 3 signals
  logic                 v3_q;
  logic signed [bpc_pkg::PcompW-1:0] pc3_q, pc3_d;
  logic [MagW-1:0]      tmag3_q;
  logic                 tneg3_q;

  // Stage 1: coefficient-by-temperature products, temperature numerator
  always_comb begin
    ct1_d   = 24'(coef_i.c12) * 24'(temperature_count_i);
    bt1_d   = $signed({{10{coef_i.b2[15]}}, coef_i.b2}) *
              $signed({16'd0, temperature_count_i});
    tmul    = 17'(temperature_count_i) * 17'd100;
    tnum    = 18'sd63175 - $signed({1'b0, tmul});
    tneg1_d = tnum[17];
    tabs    = tneg1_d ? 18'(-tnum) : 18'(tnum);
    tmag1_d = (MagW'(tabs[15:0]) << OUT_FRAC_BITS) + MagW'(267);
  end

  // Stage 2: slope times pressure, offset plus temperature term
  always_comb begin
    inner = $signed({coef_i.b1[15], coef_i.b1, 9'd0}) + $signed({2'b00, ct1_q});
    vp2_d = $signed({{10{inner[25]}}, inner}) * $signed({26'd0, p1_q});
    w2_d  = $signed({coef_i.a0[15], coef_i.a0, 19'd0}) +
            $signed({{2{bt1_q[25]}}, bt1_q, 8'd0});
  end

  // Stage 3: final sum
  assign pc3_d = $signed({{2{vp2_q[35]}}, vp2_q}) + $signed({{2{w2_q[35]}}, w2_q});

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q    <= pressure_count_i;
      ct1_q   <= ct1_d;
      bt1_q   <= bt1_d;
      tmag1_q <= tmag1_d;
      tneg1_q <= tneg1_d;
      vp2_q   <= vp2_d;
      w2_q    <= w2_d;
      tmag2_q <= tmag1_q;
      tneg2_q <= tneg1_q;
      pc3_q   <= pc3_d;
      tmag3_q <= tmag2_q;
      tneg3_q <= tneg2_q;
    end
  end

  assign valid_o = v3_q;
  assign pcomp_o = pc3_q;
  assign tmag_o  = tmag3_q;
  assign tneg_o  = tneg3_q;

endmodule

FILE: rtl/bpc_cdiv.sv
// Two-stage division by a constant: reciprocal multiply, then one
// compare-and-subtract correction.
module bpc_cdiv #(
  parameter int NUM_W   = 25,
  parameter int DIVISOR = 1023,
  localparam int Q_W    = NUM_W - 9
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  output logic [Q_W-1:0]   quot_o
);

  localparam int          Shift = NUM_W + 10;
  localparam logic [63:0] Recip = (64'd1 << Shift) / DIVISOR;
  localparam int          RecW  = $clog2(Recip + 64'd1);
  localparam int          ProdW = NUM_W + RecW;

  logic [ProdW-1:0] prod_q, prod_d;
  logic [NUM_W-1:0] num_q;
  logic [NUM_W-1:0] q_est;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] q_fix;
  logic [Q_W-1:0]   quot_q;

  // Stage 1: estimate, at most one short
  assign prod_d = ProdW'(num_i) * ProdW'(Recip[RecW-1:0]);

  // Stage 2: remainder check
  always_comb begin
    q_est = NUM_W'(prod_q >> Shift);
    rem   = num_q - NUM_W'(q_est * NUM_W'(DIVISOR));
    q_fix = (rem >= NUM_W'(DIVISOR)) ? q_est + NUM_W'(1) : q_est;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      num_q  <= num_i;
      quot_q <= q_fix[Q_W-1:0];
    end
  end

  assign quot_o = quot_q;

endmodule

FILE: rtl/barometric_pressure_compensation_unit.sv
// Barometric pressure compensation. Each request carries a 10-bit pressure
// count and a 10-bit temperature count; each result gives pressure in kPa and
// temperature in degC, both with OUT_FRAC_BITS fractional bits and rounded
// to nearest, plus a flag set when the compensated pressure had to be held
// to 0..1023. One request is taken every clock cycle, but the pipeline moves
// as a whole: while a result waits on the output the whole pipe holds and
// s_axis_tready is low. Stages: three for the compensation polynomial,
// one for the saturation, one for the kPa numerator, two for the constant
// dividers (by 1023 and by 535, run side by side) and the output register.
// The user must write coefficients through the cfg port while no request
// is in flight, unchecked by the block; they take effect on the next request.
module barometric_pressure_compensation_unit #(
  parameter int OUT_FRAC_BITS = bpc_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Coefficient write port
  input  logic                              cfg_we_i,
  input  logic [bpc_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [bpc_pkg::CoefW-1:0]         cfg_wdata_i,
  // Request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] pressure_count, [19:10] temperature_count, [23:20] zero
  input  logic [bpc_pkg::InDataW-1:0]       s_axis_tdata,
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [14:0] pressure_kpa_q8, [30:15] temperature_c_q8, [31] zero
  output logic [bpc_pkg::OutDataW-1:0]      m_axis_tdata,
  // [0] pressure_clipped
  output logic                              m_axis_tuser
);

  localparam int MagW = 16 + OUT_FRAC_BITS;
  localparam int KW   = 17 + OUT_FRAC_BITS;
  localparam int QkW  = KW - 9;
  localparam int QtW  = MagW - 9;

  logic en;

  bpc_pkg::bpc_coef_t coef;

  logic                                 v3;
  logic signed [bpc_pkg::PcompW-1:0]    pc3;
  logic [MagW-1:0]                      tmag3;
  logic                                 tneg3;

  logic                                 v4_q, v5_q, v6_q, v7_q, vo_q;
  logic [bpc_pkg::PcompClipW-1:0]       pcc4_q, pcc4_d;
  logic                                 clip4_q, clip4_d;
  logic [MagW-1:0]                      tmag4_q;
  logic                                 tneg4_q;

  logic [39:0]                          ksum;
  logic [KW-1:0]                        m5_q, m5_d;
  logic                                 clip5_q, clip6_q, clip7_q;
  logic [MagW-1:0]                      tmag5_q;
  logic                                 tneg5_q, tneg6_q, tneg7_q;

  logic [QkW-1:0]                       quot_k;
  logic [QtW-1:0]                       quot_t;
  logic [31:0]                          kpa_full;
  logic [31:0]                          degc_full;
  logic [bpc_pkg::KpaW-1:0]             kpa_q;
  logic [bpc_pkg::DegcW-1:0]            degc_q;
  logic                                 clipo_q;

  // Whole pipe advances unless a result is stuck on the output
  assign en            = !vo_q || m_axis_tready;
  assign s_axis_tready = en;

  bpc_coef u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  bpc_poly #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_poly (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .en_i                (en),
    .valid_i             (s_axis_tvalid),
    .pressure_count_i    (s_axis_tdata[9:0]),
    .temperature_count_i (s_axis_tdata[19:10]),
    .coef_i              (coef),
    .valid_o             (v3),
    .pcomp_o             (pc3),
    .tmag_o              (tmag3),
    .tneg_o              (tneg3)
  );

  // Stage 4: saturate compensated pressure to 0..1023
  always_comb begin
    pcc4_d  = pc3[bpc_pkg::PcompClipW-1:0];
    clip4_d = 1'b0;
    if (pc3[bpc_pkg::PcompW-1]) begin
      pcc4_d  = '0;
      clip4_d = 1'b1;
    end else if (pc3 > $signed(bpc_pkg::PcompW'(bpc_pkg::PcompMax))) begin
      pcc4_d  = bpc_pkg::PcompMax;
      clip4_d = 1'b1;
    end
  end

  // Stage 5: kPa numerator, 65*Pcomp plus half the divisor, scaled
  always_comb begin
    ksum = (40'(pcc4_q) << 6) + 40'(pcc4_q) + (40'(1023) << (21 - OUT_FRAC_BITS));
    m5_d = KW'(ksum >> (22 - OUT_FRAC_BITS));
  end

  // Stages 6 and 7: divide by 1023 and by 535
  bpc_cdiv #(
    .NUM_W   (KW),
    .DIVISOR (bpc_pkg::KpaDivisor)
  ) u_div_kpa (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (m5_q),
    .quot_o (quot_k)
  );

  bpc_cdiv #(
    .NUM_W   (MagW),
    .DIVISOR (bpc_pkg::DegcDivisor)
  ) u_div_degc (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (tmag5_q),
    .quot_o (quot_t)
  );

  // Output: add the 50 kPa offset, restore temperature sign
  always_comb begin
    kpa_full  = 32'(quot_k) + (32'd50 << OUT_FRAC_BITS);
    degc_full = tneg7_q ? -32'(quot_t) : 32'(quot_t);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      vo_q <= v7_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      pcc4_q  <= pcc4_d;
      clip4_q <= clip4_d;
      tmag4_q <= tmag3;
      tneg4_q <= tneg3;
      m5_q    <= m5_d;
      clip5_q <= clip4_q;
      tmag5_q <= tmag4_q;
      tneg5_q <= tneg4_q;
      clip6_q <= clip5_q;
      tneg6_q <= tneg5_q;
      clip7_q <= clip6_q;
      tneg7_q <= tneg6_q;
      kpa_q   <= kpa_full[bpc_pkg::KpaW-1:0];
      degc_q  <= degc_full[bpc_pkg::DegcW-1:0];
      clipo_q <= clip7_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {1'b0, degc_q, kpa_q};
  assign m_axis_tuser  = clipo_q;

endmodule

FILE: rtl/bpc_checker.sv
module bpc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tvalid_i,
  input logic                          s_tready_i,
  input logic                          m_tvalid_i,
  input logic                          m_tready_i,
  input logic [bpc_pkg::OutDataW-1:0]  m_tdata_i,
  input logic                          m_tuser_i
);

  // Result held stable while the sink stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("result changed while stalled");

  // A stalled output freezes the whole pipe
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |-> !s_tready_i)
    else $error("request taken while output stalled");

  // Empty output slot never holds back requests
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_i |-> s_tready_i)
    else $error("request refused with empty output");

  // No result in the cycle after reset has been seen
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_tvalid_i)
    else $error("result shown during reset");

  // Spare top bit of the result word stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> !m_tdata_i[bpc_pkg::OutDataW-1])
    else $error("padding bit set");

endmodule

bind barometric_pressure_compensation_unit bpc_checker u_bpc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata),
  .m_tuser_i  (m_axis_tuser)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bpc_pkg::*;

  localparam int FracBits = OUT_FRAC_BITS_DEF;
  localparam longint Scale = longint'(1) << FracBits;
  // Full-scale compensated pressure (1023) in units of 2^-22
  localparam longint PcompFull = longint'(KpaDivisor) << PcompFrac;
  localparam int PipeDepth = 8;

  // One pressure/temperature reading as the block returns it
  typedef struct packed {
    logic [KpaW-1:0]         kpa;
    logic signed [DegcW-1:0] degc;
    logic                    clipped;
  } reading_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = CFG_A0;
  logic [CoefW-1:0]    cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  // Shadow copy of the coefficient registers
  longint coef_a0 = 0;
  longint coef_b1 = 0;
  longint coef_b2 = 0;
  longint coef_c12 = 0;

  reading_t expected_readings[$];
  int       error_count = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  // Long receiver hold-off: requested by the test sequence, counted by the receiver
  int       stall_requests = 0;
  int       stall_granted = 0;
  int       stall_cycles_left = 0;
  int       stall_length = 0;

  barometric_pressure_compensation_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Exact compensation, saturation and both unit conversions
  function automatic reading_t compensate(input logic [CountW-1:0] p_cnt,
                                          input logic [CountW-1:0] t_cnt);
    longint p;
    longint t;
    longint pcomp;
    longint kpa_num;
    longint degc_num;
    longint degc;
    reading_t r;
    p = longint'(p_cnt);
    t = longint'(t_cnt);
    r.clipped = 1'b0;
    // all terms in units of 2^-22
    pcomp = coef_a0 * 524288 + (coef_b1 * 512 + coef_c12 * t) * p + coef_b2 * 256 * t;
    if (pcomp < 0) begin
      pcomp = 0;
      r.clipped = 1'b1;
    end else if (pcomp > PcompFull) begin
      pcomp = PcompFull;
      r.clipped = 1'b1;
    end
    kpa_num = 65 * pcomp * Scale + 50 * Scale * PcompFull;
    r.kpa = KpaW'((kpa_num + PcompFull / 2) / PcompFull);
    // (T-498)/-5.35 + 25 scaled by 100/100, rounded half away from zero
    degc_num = (63175 - 100 * t) * Scale;
    if (degc_num >= 0) begin
      degc = (degc_num + DegcDivisor / 2) / DegcDivisor;
    end else begin
      degc = -((-degc_num + DegcDivisor / 2) / DegcDivisor);
    end
    r.degc = DegcW'(degc);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Receiver: random back-pressure, or a long hold-off on request
  always @(posedge clk_i) begin
    if (stall_cycles_left > 0) begin
      stall_cycles_left <= stall_cycles_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_granted != stall_requests) begin
      stall_granted <= stall_requests;
      stall_cycles_left <= stall_length;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin : check_results
    reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unrequested result, tdata", m_axis_tdata, 0);
      end else begin
        want = expected_readings.pop_front();
        if (m_axis_tdata[KpaW-1:0] !== want.kpa)
          report_mismatch("pressure_kpa_q8", m_axis_tdata[KpaW-1:0], want.kpa);
        if ($signed(m_axis_tdata[KpaW +: DegcW]) !== want.degc)
          report_mismatch("temperature_c_q8", $signed(m_axis_tdata[KpaW +: DegcW]),
                          want.degc);
        if (m_axis_tuser !== want.clipped)
          report_mismatch("pressure_clipped", m_axis_tuser, want.clipped);
      end
    end
  end

  task automatic wait_drained();
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  // Write all four coefficients while the pipe is empty
  task automatic load_coefs(input logic [CoefW-1:0] a0, input logic [CoefW-1:0] b1,
                            input logic [CoefW-1:0] b2, input logic [CoefW-1:0] c12);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= CFG_A0;
    cfg_wdata_i <= a0;
    @(posedge clk_i);
    cfg_addr_i <= CFG_B1;
    cfg_wdata_i <= b1;
    @(posedge clk_i);
    cfg_addr_i <= CFG_B2;
    cfg_wdata_i <= b2;
    @(posedge clk_i);
    cfg_addr_i <= CFG_C12;
    cfg_wdata_i <= c12;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    coef_a0 = longint'($signed(a0));
    coef_b1 = longint'($signed(b1));
    coef_b2 = longint'($signed(b2));
    coef_c12 = longint'(c12[C12W-1:0]);
    @(posedge clk_i);
  endtask

  // Offer one request, with an optional random gap before it
  task automatic send_sample(input logic [CountW-1:0] p, input logic [CountW-1:0] t);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataW - 2 * CountW){1'b0}}, t, p};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_readings.push_back(compensate(p, t));
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // All coefficients zero: pressure sits at 50 kPa, temperature spans its range
  task automatic test_reset_coefs();
    send_sample(10'd0, 10'd0);
    send_sample(10'd1023, 10'd1023);
    send_sample(10'd0, 10'd1023);
    send_sample(10'd1023, 10'd0);
    send_sample(10'd512, 10'd498);
    stop_sending();
  endtask

  // Compensated pressure at full scale, just over it, and below zero
  task automatic test_saturation();
    load_coefs(16'sd8184, 16'sd0, 16'sd0, 16'd0);
    send_sample(10'd0, 10'd0);
    send_sample(10'd1023, 10'd1023);
    stop_sending();
    load_coefs(16'sd8185, 16'sd0, 16'sd0, 16'd0);
    send_sample(10'd0, 10'd0);
    stop_sending();
    load_coefs(-16'sd1, 16'sd0, 16'sd0, 16'd0);
    send_sample(10'd0, 10'd0);
    stop_sending();
    load_coefs(16'sd0, -16'sd32768, 16'sd0, 16'd0);
    send_sample(10'd1023, 10'd0);
    stop_sending();
  endtask

  // Coefficient extremes; bits of c12 above its width must be dropped
  task automatic test_coef_extremes();
    load_coefs(16'sd32767, 16'sd32767, 16'sd32767, 16'hFFFF);
    send_sample(10'd1023, 10'd1023);
    send_sample(10'd0, 10'd0);
    stop_sending();
    load_coefs(-16'sd32768, -16'sd32768, -16'sd32768, 16'hC000);
    send_sample(10'd1023, 10'd1023);
    send_sample(10'd1, 10'd1);
    stop_sending();
  endtask

  // Random samples over several coefficient sets and idle mixes
  task automatic test_random_traffic();
    logic [CoefW-1:0] a0;
    logic [CoefW-1:0] b1;
    logic [CoefW-1:0] b2;
    logic [CoefW-1:0] c12;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          tx_idle_pct = 36;
          rx_idle_pct = 80;
        end
        1: begin
          tx_idle_pct = 80;
          rx_idle_pct = 36;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (phase % 2 == 0) begin
        // typical sensor trim with some spread
        a0 = CoefW'(16072 + $urandom_range(800) - 400);
        b1 = CoefW'(-19400 + $urandom_range(2000) - 1000);
        b2 = CoefW'(-15100 + $urandom_range(2000) - 1000);
        c12 = CoefW'(3300 + $urandom_range(600) - 300);
      end else begin
        a0 = $urandom();
        b1 = $urandom();
        b2 = $urandom();
        c12 = $urandom();
      end
      load_coefs(a0, b1, b2, c12);
      for (int n = 0; n < 325; n++) begin
        send_sample(CountW'($urandom()), CountW'($urandom()));
      end
      stop_sending();
    end
  endtask

  // Output held off long enough to fill the pipe, then a full pause
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 20;
    load_coefs(16'sd16072, -16'sd19400, -16'sd15100, 16'd3300);
    stall_length = 300;
    stall_requests++;
    for (int n = 0; n < 40; n++) send_sample(CountW'($urandom()), CountW'($urandom()));
    stop_sending();
    wait_drained();
    for (int n = 0; n < 20; n++) send_sample(CountW'($urandom()), CountW'($urandom()));
    stop_sending();
  endtask

  initial begin
    tx_idle_pct = 36;
    rx_idle_pct = 80;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_coefs();
    test_saturation();
    test_coef_extremes();
    test_random_traffic();
    test_output_stall();
    wait_drained();
    repeat (2 * PipeDepth) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
